### src/lcdw_pkg.sv
// Shared types and constants of the LCD window frame generator.
// Used by the front, queue, back and top-level modules; depends on nothing.
package lcdw_pkg;

  // Panel size defaults
  localparam int PANEL_WIDTH_DEF  = 240;
  localparam int PANEL_HEIGHT_DEF = 320;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int COORD_W  = 16;
  localparam int BYTE_W   = 8;
  localparam int BUDGET_W = 17;
  localparam int STEP_W   = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [BUDGET_W-1:0] BUDGET_MAX = '1;

  // Input command codes
  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RECT  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCESS_CONTROL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_ON      = 2'd2;

  // Configuration reset values
  localparam logic [BYTE_W-1:0] PIXEL_FORMAT_RESET   = 8'h55;
  localparam logic [BYTE_W-1:0] ACCESS_CONTROL_RESET = 8'h00;
  localparam logic              INVERT_ON_RESET      = 1'b1;

  // Panel command bytes
  localparam logic [BYTE_W-1:0] OP_SWRESET = 8'h01;
  localparam logic [BYTE_W-1:0] OP_SLPOUT  = 8'h11;
  localparam logic [BYTE_W-1:0] OP_NORON   = 8'h13;
  localparam logic [BYTE_W-1:0] OP_INVOFF  = 8'h20;
  localparam logic [BYTE_W-1:0] OP_INVON   = 8'h21;
  localparam logic [BYTE_W-1:0] OP_DISPON  = 8'h29;
  localparam logic [BYTE_W-1:0] OP_CASET   = 8'h2A;
  localparam logic [BYTE_W-1:0] OP_RASET   = 8'h2B;
  localparam logic [BYTE_W-1:0] OP_RAMWR   = 8'h2C;
  localparam logic [BYTE_W-1:0] OP_MADCTL  = 8'h36;
  localparam logic [BYTE_W-1:0] OP_COLMOD  = 8'h3A;

  // Kind of frame burst the back end plays out
  typedef enum logic [1:0] {
    JOB_INIT,
    JOB_WIN,
    JOB_PIX
  } job_kind_t;

  // One queued burst description
  typedef struct packed {
    job_kind_t            kind;
    logic                 with_color;
    logic [COORD_W-1:0]   x0;
    logic [COORD_W-1:0]   x1;
    logic [COORD_W-1:0]   y0;
    logic [COORD_W-1:0]   y1;
    logic [COORD_W-1:0]   color;
    logic [BUDGET_W-1:0]  pixels_left;
  } job_entry_t;

  // Register values the back end needs for init
  typedef struct packed {
    logic [BYTE_W-1:0] pixel_format;
    logic [BYTE_W-1:0] access_control;
    logic              invert_on;
  } cfg_t;

endpackage

### src/lcdw_front.sv
// Front end: accepts request words, drops off-panel and unbudgeted items,
// clips windows and keeps the pixel budget. Depends on lcdw_pkg.
module lcdw_front #(
  parameter int PANEL_WIDTH  = lcdw_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = lcdw_pkg::PANEL_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [lcdw_pkg::CMD_W-1:0]    cmd,
  input  logic [lcdw_pkg::COORD_W-1:0]  x_start,
  input  logic [lcdw_pkg::COORD_W-1:0]  y_start,
  input  logic [lcdw_pkg::COORD_W-1:0]  rect_width,
  input  logic [lcdw_pkg::COORD_W-1:0]  rect_height,
  input  logic [lcdw_pkg::COORD_W-1:0]  color,
  output logic                          push,
  output lcdw_pkg::job_entry_t          push_entry,
  input  logic                          queue_full
);
  import lcdw_pkg::*;

  localparam int WW = $clog2(PANEL_WIDTH + 1);
  localparam int HH = $clog2(PANEL_HEIGHT + 1);
  localparam int PW = (WW + HH > BUDGET_W) ? WW + HH : BUDGET_W;

  logic                 s1_valid;
  logic [CMD_W-1:0]     s1_cmd;
  logic                 s1_off;
  logic [COORD_W-1:0]   s1_x;
  logic [COORD_W-1:0]   s1_y;
  logic [WW-1:0]        s1_w;
  logic [HH-1:0]        s1_h;
  logic [COORD_W-1:0]   s1_color;
  logic [BUDGET_W-1:0]  budget;
  logic [BUDGET_W-1:0]  budget_next;

  logic                 accept;
  logic                 advance;
  logic                 drop;
  logic                 off_panel;
  logic                 x_over;
  logic                 y_over;
  logic [WW-1:0]        w_clip;
  logic [HH-1:0]        h_clip;
  logic [PW-1:0]        prod;
  logic [BUDGET_W-1:0]  prod_sat;

  // Classify and clip on the incoming word
  always_comb begin
    off_panel = (x_start >= COORD_W'(PANEL_WIDTH)) || (y_start >= COORD_W'(PANEL_HEIGHT));
    x_over = ({1'b0, x_start} + {1'b0, rect_width}) > (COORD_W + 1)'(PANEL_WIDTH);
    y_over = ({1'b0, y_start} + {1'b0, rect_height}) > (COORD_W + 1)'(PANEL_HEIGHT);
    w_clip = x_over ? WW'(COORD_W'(PANEL_WIDTH) - x_start) : WW'(rect_width);
    h_clip = y_over ? HH'(COORD_W'(PANEL_HEIGHT) - y_start) : HH'(rect_height);
    if (cmd == CMD_DRAW) begin
      w_clip = WW'(1);
      h_clip = HH'(1);
    end
  end

  // Size the window, settle drops and the new budget
  always_comb begin
    prod     = PW'(s1_w) * PW'(s1_h);
    prod_sat = (prod > PW'(BUDGET_MAX)) ? BUDGET_MAX : BUDGET_W'(prod);
    drop     = 1'b0;
    budget_next = budget;
    push_entry.kind       = JOB_WIN;
    push_entry.with_color = 1'b0;
    case (s1_cmd)
      CMD_INIT: begin
        push_entry.kind = JOB_INIT;
        budget_next     = '0;
      end
      CMD_DRAW: begin
        drop                  = s1_off;
        push_entry.with_color = 1'b1;
        budget_next           = '0;
      end
      CMD_RECT: begin
        drop        = s1_off;
        budget_next = prod_sat;
      end
      CMD_PIXEL: begin
        push_entry.kind = JOB_PIX;
        drop            = (budget == '0);
        budget_next     = budget - BUDGET_W'(1);
      end
      default: begin
        drop = 1'b1;
      end
    endcase
    push_entry.x0          = s1_x;
    push_entry.y0          = s1_y;
    push_entry.x1          = COORD_W'(s1_x + COORD_W'(s1_w) - COORD_W'(1));
    push_entry.y1          = COORD_W'(s1_y + COORD_W'(s1_h) - COORD_W'(1));
    push_entry.color       = s1_color;
    push_entry.pixels_left = budget_next;
  end

  // Handshake between the input stage and the queue
  assign advance    = s1_valid && (drop || !queue_full);
  assign push       = s1_valid && !drop && !queue_full;
  assign item_stall = s1_valid && !advance;
  assign accept     = item_valid && !item_stall;

  // Hold stage valid and the budget
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      budget   <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance && !drop) begin
        budget <= budget_next;
      end
    end
  end

  // Capture the stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd   <= cmd;
      s1_off   <= off_panel;
      s1_x     <= x_start;
      s1_y     <= y_start;
      s1_w     <= w_clip;
      s1_h     <= h_clip;
      s1_color <= color;
    end
  end

  a_pix_decrements: assert property (@(posedge clk) disable iff (rst)
    push && s1_cmd == CMD_PIXEL |=> budget == $past(budget) - BUDGET_W'(1))
    else $error("pixel word did not decrement the budget");

  a_pix_needs_budget: assert property (@(posedge clk) disable iff (rst)
    push && s1_cmd == CMD_PIXEL |-> budget != '0)
    else $error("pixel word queued with an empty budget");

  a_off_panel_no_push: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_off && (s1_cmd == CMD_DRAW || s1_cmd == CMD_RECT) |-> !push)
    else $error("off-panel window reached the queue");

endmodule

### src/lcdw_queue.sv
// Short register queue of burst descriptions between front and back.
// Depends on lcdw_pkg for the entry type.
module lcdw_queue #(
  parameter int DEPTH = lcdw_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  lcdw_pkg::job_entry_t  push_entry,
  output logic                  full,
  input  logic                  pop,
  output lcdw_pkg::job_entry_t  pop_entry,
  output logic                  nonempty
);
  import lcdw_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_entry_t        slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full      = (count == CNT_W'(DEPTH));
  assign nonempty  = (count != '0);
  assign pop_entry = slots[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> nonempty)
    else $error("pop from an empty queue");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + CNT_W'(1))
    else $error("queue count did not follow a push");

endmodule

### src/lcdw_back.sv
// Back end: plays out one queued burst as panel frames, one frame a cycle
// unless frame_stall holds it, through a registered output. Depends on lcdw_pkg.
module lcdw_back (
  input  logic                          clk,
  input  logic                          rst,
  input  lcdw_pkg::cfg_t                cfg,
  input  logic                          job_ready,
  input  lcdw_pkg::job_entry_t          job_entry,
  output logic                          pop,
  output logic                          frame_valid,
  input  logic                          frame_stall,
  output logic                          frame_is_data,
  output logic [lcdw_pkg::BYTE_W-1:0]   frame_byte,
  output logic                          last,
  output logic [lcdw_pkg::BUDGET_W-1:0] pixels_left
);
  import lcdw_pkg::*;

  localparam logic [STEP_W-1:0] INIT_LAST = 4'd8;
  localparam logic [STEP_W-1:0] WIN_LAST  = 4'd10;
  localparam logic [STEP_W-1:0] DRAW_LAST = 4'd12;
  localparam logic [STEP_W-1:0] PIX_LAST  = 4'd1;

  job_entry_t         job;
  logic               job_valid;
  logic [STEP_W-1:0]  step;
  logic               load;
  logic               job_last;
  logic               f_is_data;
  logic [BYTE_W-1:0]  f_byte;

  // Pick the frame for the current step
  always_comb begin
    f_is_data = 1'b1;
    f_byte    = '0;
    job_last  = 1'b0;
    case (job.kind)
      JOB_INIT: begin
        job_last  = (step == INIT_LAST);
        f_is_data = 1'b0;
        case (step)
          4'd0: f_byte = OP_SWRESET;
          4'd1: f_byte = OP_SLPOUT;
          4'd2: f_byte = OP_COLMOD;
          4'd3: begin
            f_is_data = 1'b1;
            f_byte    = cfg.pixel_format;
          end
          4'd4: f_byte = OP_MADCTL;
          4'd5: begin
            f_is_data = 1'b1;
            f_byte    = cfg.access_control;
          end
          4'd6: f_byte = cfg.invert_on ? OP_INVON : OP_INVOFF;
          4'd7: f_byte = OP_NORON;
          default: f_byte = OP_DISPON;
        endcase
      end
      JOB_WIN: begin
        job_last = job.with_color ? (step == DRAW_LAST) : (step == WIN_LAST);
        case (step)
          4'd0: begin
            f_is_data = 1'b0;
            f_byte    = OP_CASET;
          end
          4'd1: f_byte = job.x0[15:8];
          4'd2: f_byte = job.x0[7:0];
          4'd3: f_byte = job.x1[15:8];
          4'd4: f_byte = job.x1[7:0];
          4'd5: begin
            f_is_data = 1'b0;
            f_byte    = OP_RASET;
          end
          4'd6: f_byte = job.y0[15:8];
          4'd7: f_byte = job.y0[7:0];
          4'd8: f_byte = job.y1[15:8];
          4'd9: f_byte = job.y1[7:0];
          4'd10: begin
            f_is_data = 1'b0;
            f_byte    = OP_RAMWR;
          end
          4'd11: f_byte = job.color[15:8];
          default: f_byte = job.color[7:0];
        endcase
      end
      JOB_PIX: begin
        job_last = (step == PIX_LAST);
        f_byte   = (step == '0) ? job.color[15:8] : job.color[7:0];
      end
      default: begin
        job_last = 1'b1;
      end
    endcase
  end

  // Load a frame when the output register frees; refill the job on its last frame
  assign load = job_valid && (!frame_valid || !frame_stall);
  assign pop  = job_ready && (!job_valid || (load && job_last));

  // Hold job control and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid   <= 1'b0;
      step        <= '0;
      frame_valid <= 1'b0;
    end else begin
      if (pop) begin
        job_valid <= 1'b1;
        step      <= '0;
      end else if (load) begin
        if (job_last) begin
          job_valid <= 1'b0;
        end else begin
          step <= step + STEP_W'(1);
        end
      end
      if (load) begin
        frame_valid <= 1'b1;
      end else if (!frame_stall) begin
        frame_valid <= 1'b0;
      end
    end
  end

  // Capture job and frame payload
  always_ff @(posedge clk) begin
    if (pop) begin
      job <= job_entry;
    end
    if (load) begin
      frame_is_data <= f_is_data;
      frame_byte    <= f_byte;
      last          <= job_last;
      pixels_left   <= job.pixels_left;
    end
  end

  a_step_advance: assert property (@(posedge clk) disable iff (rst)
    load && !job_last && !pop |=> job_valid && step == $past(step) + STEP_W'(1))
    else $error("burst step did not advance");

  a_pop_restarts: assert property (@(posedge clk) disable iff (rst)
    pop |=> job_valid && step == '0)
    else $error("new burst did not start at its first frame");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> step <= DRAW_LAST)
    else $error("burst step ran past the longest burst");

endmodule

### src/lcd_window_frame_generator.sv
// Top level of the LCD window frame generator: configuration registers and
// the front / queue / back chain. Depends on lcdw_pkg and the lcdw_* modules.
//
//   channel   signals                                        moves
//   item      item_valid / item_stall, cmd .. color          one request word
//   frame     frame_valid / frame_stall, frame_is_data ..    one 9-bit panel frame
//   config    cfg_we, cfg_index, cfg_data                    one register write
//
// The back end sends one frame per cycle from its output register unless
// frame_stall holds it: a pixel word sends 2 frames, a draw-pixel word 13,
// a rectangle 11 and init 9. A dropped word passes the front stage and sends nothing.
// A four-entry queue between front and back lets words enter while frames
// are stalled; the front stalls only when the queue is full.
// Reset is synchronous: it empties the stages and queue, zeroes the pixel
// budget and returns the registers to their reset values.
module lcd_window_frame_generator #(
  parameter int PANEL_WIDTH  = lcdw_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = lcdw_pkg::PANEL_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lcdw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lcdw_pkg::BYTE_W-1:0]    cfg_data,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic [lcdw_pkg::CMD_W-1:0]     cmd,
  input  logic [lcdw_pkg::COORD_W-1:0]   x_start,
  input  logic [lcdw_pkg::COORD_W-1:0]   y_start,
  input  logic [lcdw_pkg::COORD_W-1:0]   rect_width,
  input  logic [lcdw_pkg::COORD_W-1:0]   rect_height,
  input  logic [lcdw_pkg::COORD_W-1:0]   color,
  output logic                           frame_valid,
  input  logic                           frame_stall,
  output logic                           frame_is_data,
  output logic [lcdw_pkg::BYTE_W-1:0]    frame_byte,
  output logic                           last,
  output logic [lcdw_pkg::BUDGET_W-1:0]  pixels_left
);
  import lcdw_pkg::*;

  cfg_t        cfg;
  logic        push;
  logic        pop;
  logic        queue_full;
  logic        queue_nonempty;
  job_entry_t  push_entry;
  job_entry_t  pop_entry;

  // Write configuration registers; ignore unused indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_format   <= PIXEL_FORMAT_RESET;
      cfg.access_control <= ACCESS_CONTROL_RESET;
      cfg.invert_on      <= INVERT_ON_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PIXEL_FORMAT:   cfg.pixel_format   <= cfg_data;
        REG_ACCESS_CONTROL: cfg.access_control <= cfg_data;
        REG_INVERT_ON:      cfg.invert_on      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  lcdw_front #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .cmd         (cmd),
    .x_start     (x_start),
    .y_start     (y_start),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .color       (color),
    .push        (push),
    .push_entry  (push_entry),
    .queue_full  (queue_full)
  );

  lcdw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .nonempty   (queue_nonempty)
  );

  lcdw_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .job_ready     (queue_nonempty),
    .job_entry     (pop_entry),
    .pop           (pop),
    .frame_valid   (frame_valid),
    .frame_stall   (frame_stall),
    .frame_is_data (frame_is_data),
    .frame_byte    (frame_byte),
    .last          (last),
    .pixels_left   (pixels_left)
  );

endmodule

### tb/tb_lcd_window_frame_generator.sv
// Self-checking testbench for lcd_window_frame_generator: a queued word driver,
// a frame monitor and an in-bench predictor of the panel frame bursts.
// Depends on lcdw_pkg and the lcd_window_frame_generator RTL.
`timescale 1ns / 100ps

module tb_lcd_window_frame_generator;
  import lcdw_pkg::*;

  localparam int PANEL_W    = PANEL_WIDTH_DEF;
  localparam int PANEL_H    = PANEL_HEIGHT_DEF;
  localparam int SETTLE     = 20;
  localparam int LIMIT      = 600000;
  localparam int PHASE_WORDS = 125;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // One request word as driven on the item channel
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] rect_width;
    logic [COORD_W-1:0] rect_height;
    logic [COORD_W-1:0] color;
  } word_t;

  // One panel frame as seen on the frame channel
  typedef struct packed {
    logic                is_data;
    logic [BYTE_W-1:0]   payload;
    logic                last_flag;
    logic [BUDGET_W-1:0] pixels_after;
  } frame_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]    cfg_data = '0;
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  logic [CMD_W-1:0]     cmd = '0;
  logic [COORD_W-1:0]   x_start = '0;
  logic [COORD_W-1:0]   y_start = '0;
  logic [COORD_W-1:0]   rect_width = '0;
  logic [COORD_W-1:0]   rect_height = '0;
  logic [COORD_W-1:0]   color = '0;
  logic                 frame_valid;
  logic                 frame_stall = 1'b0;
  logic                 frame_is_data;
  logic [BYTE_W-1:0]    frame_byte;
  logic                 last;
  logic [BUDGET_W-1:0]  pixels_left;

  // Words waiting to be driven, and frames owed by the block
  word_t  pending[$];
  frame_t frames_due[$];
  frame_t burst[$];
  word_t  cur_word;
  frame_t due_frame;

  // Predictor copy of the registers and the open-window pixel count
  logic [BYTE_W-1:0]   fmt_shadow = PIXEL_FORMAT_RESET;
  logic [BYTE_W-1:0]   madctl_shadow = ACCESS_CONTROL_RESET;
  logic                inv_shadow = INVERT_ON_RESET;
  logic [BUDGET_W-1:0] open_pixels = '0;

  int idle_pct = 0;
  int stall_pct = 0;
  int words_drawn = 0;
  int errors = 0;
  int cycles = 0;

  lcd_window_frame_generator dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Frame burst building
  function automatic void add_frame(logic d, logic [BYTE_W-1:0] b);
    frame_t f;
    f.is_data = d;
    f.payload = b;
    f.last_flag = 1'b0;
    f.pixels_after = '0;
    burst.push_back(f);
  endfunction

  function automatic void add_window(logic [15:0] x0, logic [15:0] y0,
                                     logic [15:0] x1, logic [15:0] y1);
    add_frame(1'b0, OP_CASET);
    add_frame(1'b1, x0[15:8]);
    add_frame(1'b1, x0[7:0]);
    add_frame(1'b1, x1[15:8]);
    add_frame(1'b1, x1[7:0]);
    add_frame(1'b0, OP_RASET);
    add_frame(1'b1, y0[15:8]);
    add_frame(1'b1, y0[7:0]);
    add_frame(1'b1, y1[15:8]);
    add_frame(1'b1, y1[7:0]);
    add_frame(1'b0, OP_RAMWR);
  endfunction

  // Work out the frames one accepted word causes and queue them
  task automatic predict_word(input word_t w);
    int xs, ys, ws, hs;
    longint area;
    burst.delete();
    xs = w.x_start;
    ys = w.y_start;
    ws = w.rect_width;
    hs = w.rect_height;
    case (w.cmd)
      CMD_INIT: begin
        add_frame(1'b0, OP_SWRESET);
        add_frame(1'b0, OP_SLPOUT);
        add_frame(1'b0, OP_COLMOD);
        add_frame(1'b1, fmt_shadow);
        add_frame(1'b0, OP_MADCTL);
        add_frame(1'b1, madctl_shadow);
        add_frame(1'b0, inv_shadow ? OP_INVON : OP_INVOFF);
        add_frame(1'b0, OP_NORON);
        add_frame(1'b0, OP_DISPON);
        open_pixels = '0;
      end
      CMD_DRAW: begin
        if (xs < PANEL_W && ys < PANEL_H) begin
          add_window(w.x_start, w.y_start, w.x_start, w.y_start);
          add_frame(1'b1, w.color[15:8]);
          add_frame(1'b1, w.color[7:0]);
          open_pixels = '0;
        end
      end
      CMD_RECT: begin
        if (xs < PANEL_W && ys < PANEL_H) begin
          // clip to the panel edge; a zero size wraps the end coordinate
          if (xs + ws > PANEL_W) ws = PANEL_W - xs;
          if (ys + hs > PANEL_H) hs = PANEL_H - ys;
          add_window(w.x_start, w.y_start, 16'(xs + ws - 1), 16'(ys + hs - 1));
          area = longint'(ws) * longint'(hs);
          open_pixels = (area > longint'(BUDGET_MAX)) ? BUDGET_MAX : area[BUDGET_W-1:0];
        end
      end
      CMD_PIXEL: begin
        if (open_pixels != '0) begin
          add_frame(1'b1, w.color[15:8]);
          add_frame(1'b1, w.color[7:0]);
          open_pixels = open_pixels - BUDGET_W'(1);
        end
      end
      default: ;
    endcase
    foreach (burst[i]) begin
      burst[i].pixels_after = open_pixels;
      burst[i].last_flag = (i == burst.size() - 1);
      frames_due.push_back(burst[i]);
    end
    if (burst.size() != 0) words_drawn++;
  endtask

  // Word driver: hold a stalled word, advance on acceptance
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      open_pixels = '0;
    end else begin
      if (item_valid && !item_stall) predict_word(cur_word);
      if (!item_valid || !item_stall) begin
        if (pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
          cur_word = pending.pop_front();
          item_valid  <= 1'b1;
          cmd         <= cur_word.cmd;
          x_start     <= cur_word.x_start;
          y_start     <= cur_word.y_start;
          rect_width  <= cur_word.rect_width;
          rect_height <= cur_word.rect_height;
          color       <= cur_word.color;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Frame receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      frame_stall <= 1'b0;
    end else begin
      frame_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Frame monitor: compare each accepted frame with the oldest one owed
  always @(posedge clk) begin
    if (!rst && frame_valid && !frame_stall) begin
      if (frames_due.size() == 0) begin
        $error("unexpected frame: frame_is_data %0d frame_byte %02h", frame_is_data,
               frame_byte);
        errors++;
      end else begin
        due_frame = frames_due.pop_front();
        if (frame_is_data !== due_frame.is_data) begin
          $error("frame_is_data: expected %0d, got %0d", due_frame.is_data, frame_is_data);
          errors++;
        end
        if (frame_byte !== due_frame.payload) begin
          $error("frame_byte: expected %02h, got %02h", due_frame.payload, frame_byte);
          errors++;
        end
        if (last !== due_frame.last_flag) begin
          $error("last: expected %0d, got %0d", due_frame.last_flag, last);
          errors++;
        end
        if (pixels_left !== due_frame.pixels_after) begin
          $error("pixels_left: expected %0d, got %0d", due_frame.pixels_after, pixels_left);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic queue_word(input logic [CMD_W-1:0] c, input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] w, input logic [15:0] h, input logic [15:0] col);
    word_t wd;
    wd.cmd = c;
    wd.x_start = x;
    wd.y_start = y;
    wd.rect_width = w;
    wd.rect_height = h;
    wd.color = col;
    pending.push_back(wd);
  endtask

  function automatic word_t rand_word();
    word_t wd;
    wd.cmd = CMD_W'($urandom_range(3));
    wd.x_start = COORD_W'($urandom_range(65535));
    wd.y_start = COORD_W'($urandom_range(65535));
    wd.rect_width = COORD_W'($urandom_range(65535));
    wd.rect_height = COORD_W'($urandom_range(65535));
    wd.color = COORD_W'($urandom_range(65535));
    return wd;
  endfunction

  // Mostly rectangles filled with their pixel count, sometimes one more or one fewer, plus noise
  task automatic queue_random_burst();
    word_t wd;
    int pick, wsz, hsz, npix;
    pick = $urandom_range(99);
    wd = rand_word();
    if (pick < 55) begin
      wd.cmd = CMD_RECT;
      wd.y_start = COORD_W'($urandom_range(PANEL_H - 1));
      hsz = $urandom_range(4);
      wd.rect_height = COORD_W'(hsz);
      if ($urandom_range(3) == 0) begin
        // oversized width near the right edge, clipped by the block
        wd.x_start = COORD_W'(PANEL_W - 1 - $urandom_range(3));
        wd.rect_width = COORD_W'($urandom_range(65535, 4));
        wsz = PANEL_W - wd.x_start;
      end else begin
        wd.x_start = COORD_W'($urandom_range(PANEL_W - 5));
        wsz = $urandom_range(4);
        wd.rect_width = COORD_W'(wsz);
      end
      npix = wsz * hsz;
      case ($urandom_range(7))
        0: npix = npix + 1;
        1: if (npix > 0) npix = npix - 1;
        default: ;
      endcase
      pending.push_back(wd);
      repeat (npix) begin
        wd = rand_word();
        wd.cmd = CMD_PIXEL;
        pending.push_back(wd);
      end
    end else if (pick < 70) begin
      wd.cmd = CMD_DRAW;
      wd.x_start = COORD_W'($urandom_range(PANEL_W - 1));
      wd.y_start = COORD_W'($urandom_range(PANEL_H - 1));
      pending.push_back(wd);
    end else if (pick < 75) begin
      wd.cmd = CMD_INIT;
      pending.push_back(wd);
    end else begin
      pending.push_back(wd);
    end
  endtask

  // Wait until every word is taken and every owed frame has arrived
  task automatic drain();
    while (pending.size() != 0 || item_valid || frames_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PIXEL_FORMAT:   fmt_shadow = val;
      REG_ACCESS_CONTROL: madctl_shadow = val;
      REG_INVERT_ON:      inv_shadow = val[0];
      default: ;
    endcase
  endtask

  // Random phase with one full drain of the frame stream half way
  task automatic run_random(input int count);
    int goal, half;
    bit paused;
    goal = words_drawn + count;
    half = words_drawn + count / 2;
    paused = 1'b0;
    while (words_drawn < goal) begin
      if (!paused && words_drawn >= half) begin
        drain();
        paused = 1'b1;
      end else if (pending.size() < 4) begin
        queue_random_burst();
      end else begin
        @(negedge clk);
      end
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    idle_pct = 38;
    stall_pct = 87;

    // Directed: reset registers, panel corners, drops, clipping, budget rules
    queue_word(CMD_INIT,  0, 0, 0, 0, 0);
    queue_word(CMD_DRAW,  0, 0, 0, 0, 16'hFFFF);
    queue_word(CMD_DRAW,  239, 319, 16'hFFFF, 16'hFFFF, 16'h0000);
    queue_word(CMD_DRAW,  240, 0, 0, 0, 16'h1234);
    queue_word(CMD_DRAW,  0, 320, 0, 0, 16'h1234);
    queue_word(CMD_PIXEL, 0, 0, 0, 0, 16'h1234);
    queue_word(CMD_RECT,  0, 0, 0, 0, 0);
    queue_word(CMD_PIXEL, 0, 0, 0, 0, 16'h4321);
    queue_word(CMD_RECT,  0, 0, 16'hFFFF, 16'hFFFF, 0);
    queue_word(CMD_PIXEL, 0, 0, 0, 0, 16'hA5A5);
    queue_word(CMD_PIXEL, 0, 0, 0, 0, 16'h5A5A);
    queue_word(CMD_RECT,  239, 319, 1, 1, 0);
    queue_word(CMD_PIXEL, 0, 0, 0, 0, 16'hFFFF);
    queue_word(CMD_PIXEL, 0, 0, 0, 0, 16'h0000);
    queue_word(CMD_RECT,  10, 10, 2, 1, 0);
    queue_word(CMD_RECT,  16'hFFFF, 16'hFFFF, 3, 3, 0);
    queue_word(CMD_PIXEL, 0, 0, 0, 0, 16'h0F0F);
    queue_word(CMD_RECT,  100, 200, 0, 5, 0);
    queue_word(CMD_PIXEL, 0, 0, 0, 0, 16'hF0F0);
    queue_word(CMD_RECT,  50, 60, 3, 2, 0);
    queue_word(CMD_DRAW,  5, 5, 0, 0, 16'h8001);
    queue_word(CMD_PIXEL, 0, 0, 0, 0, 16'h7FFE);
    queue_word(CMD_RECT,  1, 1, 2, 2, 0);
    queue_word(CMD_INIT,  0, 0, 0, 0, 0);
    queue_word(CMD_PIXEL, 0, 0, 0, 0, 16'h1111);
    queue_word(CMD_RECT,  200, 300, 100, 100, 0);
    queue_word(CMD_PIXEL, 0, 0, 0, 0, 16'h2222);
    drain();

    // Phase 1: slow receiver, one register setting at the extremes
    write_reg(REG_PIXEL_FORMAT, 8'hFF);
    write_reg(REG_ACCESS_CONTROL, 8'h00);
    write_reg(REG_INVERT_ON, 8'h00);
    write_reg(REG_UNUSED, 8'hA5);
    queue_word(CMD_INIT, 0, 0, 0, 0, 0);
    run_random(PHASE_WORDS);

    // Phase 2: slow sender, opposite extremes
    idle_pct = 87;
    stall_pct = 38;
    write_reg(REG_PIXEL_FORMAT, 8'h00);
    write_reg(REG_ACCESS_CONTROL, 8'hFF);
    write_reg(REG_INVERT_ON, 8'hFF);
    queue_word(CMD_INIT, 0, 0, 0, 0, 0);
    run_random(PHASE_WORDS);

    // Phase 3: full rate, random register values
    idle_pct = 0;
    stall_pct = 0;
    write_reg(REG_PIXEL_FORMAT, BYTE_W'($urandom_range(255)));
    write_reg(REG_ACCESS_CONTROL, BYTE_W'($urandom_range(255)));
    write_reg(REG_INVERT_ON, BYTE_W'($urandom_range(255)));
    queue_word(CMD_INIT, 0, 0, 0, 0, 0);
    run_random(PHASE_WORDS);

    drain();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
